### hdl/eat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eat_pkg
// shared types for the eased animation tick pipeline
// ----------------------------------------------------------------------------
package eat_pkg;

  typedef enum logic [2:0] {
    EASE_LINEAR    = 3'd0,
    EASE_QUAD_IN   = 3'd1,
    EASE_QUAD_OUT  = 3'd2,
    EASE_QUAD_IO   = 3'd3,
    EASE_CUBIC_IN  = 3'd4,
    EASE_CUBIC_OUT = 3'd5,
    EASE_QUART_IN  = 3'd6,
    EASE_QUART_OUT = 3'd7
  } ease_kind_t;

  // record fields that travel down the pipeline next to the math
  typedef struct packed {
    logic signed [31:0] cur;
    logic signed [31:0] tgt;
    logic signed [31:0] start;
    logic [31:0]        elapsed;
    logic [31:0]        dur;
    ease_kind_t         kind;
    logic               started;
    logic               done;
    logic               waiting;
  } rec_t;

endpackage

### hdl/eat_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eat_in_if / eat_out_if
// request and result channels of the eased animation tick
// ----------------------------------------------------------------------------
interface eat_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] current_value;
  logic signed [31:0] target_value;
  logic signed [31:0] start_value;
  logic [31:0]        duration_time;
  logic [31:0]        delay_time;
  logic [31:0]        elapsed_time;
  eat_pkg::ease_kind_t ease_kind;
  logic               has_started;
  logic [31:0]        frame_time;

  modport source (output valid, current_value, target_value, start_value, duration_time,
                  delay_time, elapsed_time, ease_kind, has_started, frame_time,
                  input ready);
  modport sink (input valid, current_value, target_value, start_value, duration_time,
                delay_time, elapsed_time, ease_kind, has_started, frame_time,
                output ready);
endinterface

interface eat_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_value;
  logic signed [31:0] new_start_value;
  logic [31:0]        new_elapsed_time;
  logic               new_started;
  logic               finished;

  modport source (output valid, new_value, new_start_value, new_elapsed_time,
                  new_started, finished, input ready);
  modport sink (input valid, new_value, new_start_value, new_elapsed_time,
                new_started, finished, output ready);
endinterface

### hdl/eat_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eat_div
// pipelined restoring divider, one quotient bit per stage, num < den
// ----------------------------------------------------------------------------
module eat_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [31:0]          num,
  input  logic [31:0]          den,
  output logic [FRAC_BITS-1:0] quo
);
  logic [31:0]          rem_r [FRAC_BITS];
  logic [31:0]          den_r [FRAC_BITS];
  logic [FRAC_BITS-1:0] quo_r [FRAC_BITS];

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_stage
    logic [31:0]          rem_in;
    logic [31:0]          den_in;
    logic [FRAC_BITS-1:0] quo_in;
    logic [32:0]          shifted;
    logic                 ge;

    if (i == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign den_in = den_r[i-1];
      assign quo_in = quo_r[i-1];
    end

    assign shifted = {rem_in, 1'b0};
    assign ge      = shifted >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? 32'(shifted - {1'b0, den_in}) : shifted[31:0];
        den_r[i] <= den_in;
        quo_r[i] <= {quo_in[FRAC_BITS-2:0], ge};
      end
    end
  end

  assign quo = quo_r[FRAC_BITS-1];
endmodule

### hdl/eased_animation_tick.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eased_animation_tick
// advances one animation record by one frame with easing and lerp, Q.F fixed
// ----------------------------------------------------------------------------
// pipeline: stage 1, stage 2, the divider stages, then stages 3 to 6 to the result
// throughput: one request per cycle while the output is not stalled; the FRAC_BITS-stage divider sets depth
// a stall at the output freezes the whole pipeline in place
// reset: synchronous active-low rst_n clears all stage valid bits
module eased_animation_tick #(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  eat_in_if.sink    in_if,
  eat_out_if.source out_if
);
  import eat_pkg::*;

  localparam int F = FRAC_BITS;
  localparam logic [31:0] EPS = 32'(((1 << F) + 5000) / 10000);
  localparam logic [F+1:0] ONE = (F+2)'(1) << F;
  localparam logic [F+1:0] TWO = (F+2)'(2) << F;
  localparam int PW = 34 + F;

  logic en;
  assign en          = !out_if.valid || out_if.ready;
  assign in_if.ready = en;

  // stage 1: first time add, delay check, start latch
  rec_t        s1_r;
  logic [31:0] s1_frame_r;
  logic        v1_r;
  logic [32:0] e1_sum;
  logic [31:0] e1;
  logic        wait_c;
  always_comb begin
    e1_sum = {1'b0, in_if.elapsed_time} + {1'b0, in_if.frame_time};
    e1     = e1_sum[32] ? '1 : e1_sum[31:0];
    wait_c = !in_if.has_started && (e1 < in_if.delay_time);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r.cur     <= in_if.current_value;
      s1_r.tgt     <= in_if.target_value;
      s1_r.start   <= (in_if.has_started || wait_c) ? in_if.start_value
                                                     : in_if.current_value;
      s1_r.elapsed <= in_if.has_started ? in_if.elapsed_time : (wait_c ? e1 : '0);
      s1_r.dur     <= in_if.duration_time;
      s1_r.kind    <= in_if.ease_kind;
      s1_r.started <= !wait_c;
      s1_r.done    <= 1'b0;
      s1_r.waiting <= wait_c;
      s1_frame_r   <= in_if.frame_time;
    end
  end

  // stage 2: second time add and finish check (epsilon snap, zero duration, duration reached)
  rec_t        s2_r;
  logic        v2_r;
  logic [32:0] e2_sum;
  logic [31:0] e2;
  logic [32:0] diff;
  logic [31:0] ac, at, amax, thr;
  logic        done_c;
  always_comb begin
    e2_sum = {1'b0, s1_r.elapsed} + {1'b0, s1_frame_r};
    e2     = s1_r.waiting ? s1_r.elapsed : (e2_sum[32] ? '1 : e2_sum[31:0]);
    diff   = (s1_r.cur >= s1_r.tgt)
           ? 33'({s1_r.cur[31], s1_r.cur} - {s1_r.tgt[31], s1_r.tgt})
           : 33'({s1_r.tgt[31], s1_r.tgt} - {s1_r.cur[31], s1_r.cur});
    ac     = s1_r.cur[31] ? 32'(-s1_r.cur) : s1_r.cur;
    at     = s1_r.tgt[31] ? 32'(-s1_r.tgt) : s1_r.tgt;
    amax   = (ac > at) ? ac : at;
    thr    = ((amax >> 23) < EPS) ? EPS : (amax >> 23);
    done_c = !s1_r.waiting &&
             ((diff <= {1'b0, thr}) || (s1_r.dur == '0) || (e2 >= s1_r.dur));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r         <= s1_r;
      s2_r.elapsed <= e2;
      s2_r.done    <= done_c;
    end
  end

  // divider stages, record rides alongside
  logic [F-1:0] quo;
  rec_t         sd_r [F];
  logic [F-1:0] vd_r;

  eat_div #(.FRAC_BITS(F)) u_div (
    .clk (clk),
    .en  (en),
    .num ((s2_r.done || s2_r.waiting) ? 32'd0 : s2_r.elapsed),
    .den (s2_r.dur),
    .quo (quo)
  );

  for (genvar i = 0; i < F; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) sd_r[i] <= (i == 0) ? s2_r : sd_r[(i == 0) ? 0 : i-1];
    end
  end

  // stage 3: first easing product
  rec_t         s3_r;
  logic         v3_r;
  logic [F-1:0] p3_r;
  logic         qhi3_r;
  logic [F:0]   m1_r;
  logic [F+1:0] pe, ue, x1, y1;
  logic [F:0]   q;
  logic [2*F+3:0] prod1;
  logic         sh1;
  always_comb begin
    pe  = {2'b00, quo};
    ue  = ONE - pe;
    q   = {quo, 1'b0};
    x1  = '0;
    y1  = '0;
    sh1 = 1'b0;
    unique case (sd_r[F-1].kind)
      EASE_QUAD_IN, EASE_CUBIC_IN, EASE_QUART_IN: begin
        x1 = pe; y1 = pe;
      end
      EASE_QUAD_OUT: begin
        x1 = pe; y1 = TWO - pe;
      end
      EASE_QUAD_IO: begin
        if (!q[F]) begin
          x1 = {1'b0, q}; y1 = {1'b0, q}; sh1 = 1'b1;
        end else begin
          x1 = {2'b00, q[F-1:0]}; y1 = TWO - {2'b00, q[F-1:0]};
        end
      end
      EASE_CUBIC_OUT, EASE_QUART_OUT: begin
        x1 = ue; y1 = ue;
      end
      EASE_LINEAR: begin
        x1 = '0; y1 = '0;
      end
      default: begin
        x1 = '0; y1 = '0;
      end
    endcase
    prod1 = (2*F+4)'(x1) * (2*F+4)'(y1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r   <= sd_r[F-1];
      p3_r   <= quo;
      qhi3_r <= q[F];
      m1_r   <= sh1 ? prod1[2*F+1:F+1] : prod1[2*F:F];
    end
  end

  // stage 4: second product and final eased fraction
  rec_t         s4_r;
  logic         v4_r;
  logic [F:0]   e_r;
  logic [F:0]   b2, p3e, u3, m2, e_c;
  logic [2*F+1:0] prod2;
  logic [F+1:0] half_io;
  always_comb begin
    p3e = {1'b0, p3_r};
    u3  = (F+1)'(ONE) - p3e;
    unique case (s3_r.kind)
      EASE_CUBIC_IN:  b2 = p3e;
      EASE_CUBIC_OUT: b2 = u3;
      default:        b2 = m1_r;
    endcase
    prod2   = (2*F+2)'(m1_r) * (2*F+2)'(b2);
    m2      = prod2[2*F:F];
    half_io = (ONE + {1'b0, m1_r}) >> 1;
    unique case (s3_r.kind)
      EASE_LINEAR:                   e_c = p3e;
      EASE_QUAD_IN, EASE_QUAD_OUT:   e_c = m1_r;
      EASE_QUAD_IO:                  e_c = qhi3_r ? half_io[F:0] : m1_r;
      EASE_CUBIC_IN, EASE_QUART_IN:  e_c = m2;
      EASE_CUBIC_OUT, EASE_QUART_OUT: e_c = (F+1)'(ONE) - m2;
      default:                       e_c = p3e;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_r <= s3_r;
      e_r  <= e_c;
    end
  end

  // stage 5: lerp products
  rec_t                  s5_r;
  logic                  v5_r;
  logic signed [PW-1:0]  pa_r, pb_r;
  logic signed [F+1:0]   ome_s, e_s;
  always_comb begin
    e_s   = $signed({1'b0, e_r});
    ome_s = $signed(ONE - {1'b0, e_r});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_r <= s4_r;
      pa_r <= PW'(s4_r.start) * PW'(ome_s);
      pb_r <= PW'(s4_r.tgt) * PW'(e_s);
    end
  end

  // stage 6: round, select and hold for the consumer
  rec_t               so_r;
  logic               vo_r;
  logic signed [31:0] val_r;
  logic signed [PW:0] sum;
  logic signed [31:0] val_c;
  always_comb begin
    sum = $signed({pa_r[PW-1], pa_r}) + $signed({pb_r[PW-1], pb_r})
        + $signed((PW+1)'(1) << (F - 1));
    if (s5_r.waiting)   val_c = s5_r.cur;
    else if (s5_r.done) val_c = s5_r.tgt;
    else                val_c = sum[F+31:F];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      so_r  <= s5_r;
      val_r <= val_c;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vd_r <= '0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_if.valid;
      v2_r <= v1_r;
      vd_r <= {vd_r[F-2:0], v2_r};
      v3_r <= vd_r[F-1];
      v4_r <= v3_r;
      v5_r <= v4_r;
      vo_r <= v5_r;
    end
  end

  assign out_if.valid            = vo_r;
  assign out_if.new_value        = val_r;
  assign out_if.new_start_value  = so_r.start;
  assign out_if.new_elapsed_time = so_r.elapsed;
  assign out_if.new_started      = so_r.started;
  assign out_if.finished         = so_r.done;

`ifndef SYNTH
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready |=> v1_r)
    else $error("accepted request did not enter stage one");
  a_done_snaps: assert property (@(posedge clk) disable iff (!rst_n)
    vo_r && so_r.done |-> val_r == so_r.tgt)
    else $error("finished record not snapped to target");
  a_wait_state: assert property (@(posedge clk) disable iff (!rst_n)
    vo_r && so_r.waiting |-> !so_r.started && !so_r.done && val_r == so_r.cur)
    else $error("waiting record changed value or flags");
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r && !en |=> v5_r && $stable(pa_r))
    else $error("stalled lerp stage lost its data");
`endif
endmodule
